### rtl/assert_macros.svh
// Assertion macros shared by the RTL. Both are clocked on the rising edge
// and are switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever pre holds, post holds as well.
`define PRD_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication: whenever pre holds, post holds in the cycle after.
`define PRD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/prd_pkg.sv
package prd_pkg;

    // Number of descriptors one table may hold (1 to 63).
    localparam int MAX_ENTRIES     = 32;
    localparam int SECS_PER_ENTRY  = 63;
    localparam int SECTOR_SHIFT    = 9;
    // Largest sector count that fits in the table at full-length entries.
    localparam int MAX_COUNT       = MAX_ENTRIES * SECS_PER_ENTRY;
    localparam int REM_W           = $clog2(MAX_COUNT + 1);
    localparam int N_W             = $clog2(MAX_ENTRIES + 1);
    localparam int SEC_W           = $clog2(SECS_PER_ENTRY + 1);

    localparam logic [16:0] BOUNDARY = 17'h10000;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_COUNT  = 2'd1;
    localparam logic [1:0] ST_MISALIGNED = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new request
        logic step;   // produce one result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic final_res;  // the result about to be produced ends the request
    } sts_t;

endpackage

### rtl/prd_dp.sv
module prd_dp (
    input  logic                 aclk,
    input  prd_pkg::cmd_t        cmd,
    output prd_pkg::sts_t        sts,
    input  logic [31:0]          phys_addr,
    input  logic [15:0]          sector_count,
    output logic [31:0]          entry_addr,
    output logic [15:0]          entry_bytes_m1,
    output logic                 end_of_table,
    output logic [1:0]           status,
    output logic                 last
);

    logic [31:0]                  addr_reg, addr_next;
    logic [prd_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [prd_pkg::N_W-1:0]      n_reg, n_next;
    logic                         bad_reg, bad_next;

    logic [31:0]                  o_addr_reg, o_addr_next;
    logic [15:0]                  o_bytes_reg, o_bytes_next;
    logic                         o_eot_reg, o_eot_next;
    logic [1:0]                   o_status_reg, o_status_next;
    logic                         o_last_reg, o_last_next;

    logic [prd_pkg::SEC_W-1:0]    secs_full;
    logic [prd_pkg::SEC_W-1:0]    secs;
    logic [16:0]                  room;
    logic [16:0]                  want_bytes;
    logic                         shortened;
    logic                         misaligned;
    logic                         table_full;
    logic                         eot;
    logic [1:0]                   res_status;

    always_comb begin
        if (rem_reg > prd_pkg::REM_W'(prd_pkg::SECS_PER_ENTRY)) begin
            secs_full = prd_pkg::SEC_W'(prd_pkg::SECS_PER_ENTRY);
        end else begin
            secs_full = rem_reg[prd_pkg::SEC_W-1:0];
        end
        // Bytes left before the next 64 KiB boundary (1 to 65536).
        room       = prd_pkg::BOUNDARY - {1'b0, addr_reg[15:0]};
        want_bytes = 17'({secs_full, 9'b0});
        shortened  = want_bytes > room;
        // A shortened entry is below 32 KiB, so room[14:9] holds the sectors.
        secs       = shortened ? room[prd_pkg::SEC_W+8:9] : secs_full;
        misaligned = shortened && (secs == '0);
        table_full = n_reg == prd_pkg::N_W'(prd_pkg::MAX_ENTRIES);
        eot        = rem_reg <= prd_pkg::REM_W'(secs);

        if (bad_reg) begin
            res_status = prd_pkg::ST_BAD_COUNT;
        end else if (table_full) begin
            res_status = prd_pkg::ST_FULL;
        end else if (misaligned) begin
            res_status = prd_pkg::ST_MISALIGNED;
        end else begin
            res_status = prd_pkg::ST_OK;
        end
        sts.final_res = bad_reg || table_full || misaligned || eot;
    end

    always_comb begin
        addr_next     = addr_reg;
        rem_next      = rem_reg;
        n_next        = n_reg;
        bad_next      = bad_reg;
        o_addr_next   = o_addr_reg;
        o_bytes_next  = o_bytes_reg;
        o_eot_next    = o_eot_reg;
        o_status_next = o_status_reg;
        o_last_next   = o_last_reg;
        if (cmd.load) begin
            addr_next = phys_addr;
            rem_next  = sector_count[prd_pkg::REM_W-1:0];
            n_next    = '0;
            bad_next  = (sector_count == 16'd0) ||
                        (sector_count > 16'(prd_pkg::MAX_COUNT));
        end else if (cmd.step) begin
            addr_next     = addr_reg + 32'({secs, 9'b0});
            rem_next      = rem_reg - prd_pkg::REM_W'(secs);
            n_next        = n_reg + prd_pkg::N_W'(1);
            o_status_next = res_status;
            o_last_next   = sts.final_res;
            if (res_status == prd_pkg::ST_OK) begin
                o_addr_next  = addr_reg;
                o_bytes_next = 16'({secs, 9'b0}) - 16'd1;
                o_eot_next   = eot;
            end else begin
                o_addr_next  = '0;
                o_bytes_next = '0;
                o_eot_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        rem_reg      <= rem_next;
        n_reg        <= n_next;
        bad_reg      <= bad_next;
        o_addr_reg   <= o_addr_next;
        o_bytes_reg  <= o_bytes_next;
        o_eot_reg    <= o_eot_next;
        o_status_reg <= o_status_next;
        o_last_reg   <= o_last_next;
    end

    assign entry_addr     = o_addr_reg;
    assign entry_bytes_m1 = o_bytes_reg;
    assign end_of_table   = o_eot_reg;
    assign status         = o_status_reg;
    assign last           = o_last_reg;

endmodule

### rtl/prd_ctrl.sv
`include "assert_macros.svh"

module prd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  prd_pkg::sts_t sts,
    output prd_pkg::cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = state_reg == S_IDLE;
    assign m_tvalid  = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (slot_free) begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.final_res) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PRD_ASSERT_NOW(a_step_into_free_slot, aclk, aresetn, cmd.step, slot_free, "step overwrote a waiting word")
    `PRD_ASSERT_NOW(a_no_step_when_idle, aclk, aresetn, state_reg == S_IDLE, !cmd.step, "step issued while idle")
    `PRD_ASSERT_NEXT(a_final_returns_idle, aclk, aresetn, cmd.step && sts.final_res, (state_reg == S_IDLE) && out_valid_reg, "final result did not end the request")

endmodule

### rtl/ata_prd_table_builder.sv
// ATA bus-master PRD table builder. Each input word names a physically
// contiguous buffer by its start address and a count of 512-byte sectors,
// and the block answers with one output word per physical region
// descriptor, in table order. A descriptor covers at most 63 sectors and
// never crosses a 64 KiB boundary; when the boundary shortens it, the length
// is rounded down to whole sectors and the next descriptor starts right after
// it. The table holds at most prd_pkg::MAX_ENTRIES descriptors. A zero count,
// or a count that cannot fit at full-length entries, gives a single word with
// status 1. A boundary closer than one sector gives a word with status 2,
// and running out of entries gives a word with status 3; in both cases the
// consumer must discard the descriptors of that request already received.
// Error words carry zero address, length and end-of-table flag. tlast marks
// the final word caused by each input. Timing: an input is taken while the
// controller is idle, and the controller then produces one result per cycle
// into the output register while the sink keeps pace, holding off the input
// side until the final result is produced; the next input may be taken while
// the final result still waits in the output register.
module ata_prd_table_builder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] phys_addr, [47:32] sector_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] entry_addr, [47:32] entry_bytes_m1
    output logic [2:0]  m_tuser,   // [0] end_of_table, [2:1] status
    output logic        m_tlast
);

    prd_pkg::cmd_t cmd;
    prd_pkg::sts_t sts;

    logic [31:0] entry_addr;
    logic [15:0] entry_bytes_m1;
    logic        end_of_table;
    logic [1:0]  status;
    logic        last;

    // The controller sequences the request and owns the output valid flag.
    prd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath walks the buffer one descriptor per step and holds the
    // output word.
    prd_dp u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .sts            (sts),
        .phys_addr      (s_tdata[31:0]),
        .sector_count   (s_tdata[47:32]),
        .entry_addr     (entry_addr),
        .entry_bytes_m1 (entry_bytes_m1),
        .end_of_table   (end_of_table),
        .status         (status),
        .last           (last)
    );

    assign m_tdata = {entry_bytes_m1, entry_addr};
    assign m_tuser = {status, end_of_table};
    assign m_tlast = last;

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // One descriptor word as it leaves the block.
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] bytes_m1;
        logic        eot;
        logic [1:0]  status;
        logic        last;
    } prd_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // [31:0] phys_addr, [47:32] sector_count
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // [31:0] entry_addr, [47:32] entry_bytes_m1
    logic [2:0]  m_tuser;          // [0] end_of_table, [2:1] status
    logic        m_tlast;

    prd_word_t   expected_prds[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    ata_prd_table_builder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver holds off in stall_pct cycles out of a hundred.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void push_prd(input logic [31:0] addr, input logic [15:0] bytes_m1,
                                     input logic eot, input logic [1:0] status,
                                     input logic last);
        prd_word_t w;
        w.addr     = addr;
        w.bytes_m1 = bytes_m1;
        w.eot      = eot;
        w.status   = status;
        w.last     = last;
        expected_prds.push_back(w);
    endfunction

    // Works out the descriptor table for one request and queues every word
    // that the block should send back for it, error word included.
    function automatic void predict_prd_table(input logic [31:0] base,
                                              input logic [15:0] count);
        int unsigned needed;
        int unsigned remaining;
        int unsigned done;
        int unsigned secs;
        int unsigned room;
        int unsigned n;
        logic [31:0] addr;
        logic        eot;
        needed = 32'((int'(count) + prd_pkg::SECS_PER_ENTRY - 1) / prd_pkg::SECS_PER_ENTRY);
        if (count == 16'd0 || needed > prd_pkg::MAX_ENTRIES) begin
            push_prd('0, '0, 1'b0, prd_pkg::ST_BAD_COUNT, 1'b1);
            return;
        end
        remaining = 32'(count);
        done = 0;
        n = 0;
        while (remaining > 0 && n < prd_pkg::MAX_ENTRIES) begin
            secs = (remaining < prd_pkg::SECS_PER_ENTRY) ? remaining
                                                         : prd_pkg::SECS_PER_ENTRY;
            // Address arithmetic wraps at 2^32, and the wrap is a boundary too.
            addr = base + (done << prd_pkg::SECTOR_SHIFT);
            room = 32'(prd_pkg::BOUNDARY) - 32'(addr[15:0]);
            if ((secs << prd_pkg::SECTOR_SHIFT) > room) begin
                secs = room >> prd_pkg::SECTOR_SHIFT;
                if (secs == 0) begin
                    push_prd('0, '0, 1'b0, prd_pkg::ST_MISALIGNED, 1'b1);
                    return;
                end
            end
            eot = (remaining <= secs);
            push_prd(addr, 16'((secs << prd_pkg::SECTOR_SHIFT) - 1), eot,
                     prd_pkg::ST_OK, eot);
            remaining -= secs;
            done += secs;
            n++;
        end
        if (remaining > 0) begin
            push_prd('0, '0, 1'b0, prd_pkg::ST_FULL, 1'b1);
        end
    endfunction

    // Both sides are watched in one process, so a request's words are queued
    // before anything returned at the same edge is compared.
    always @(posedge aclk) begin
        prd_word_t got;
        prd_word_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_prd_table(s_tdata[31:0], s_tdata[47:32]);
            end
            if (m_tvalid && m_tready) begin
                got.addr     = m_tdata[31:0];
                got.bytes_m1 = m_tdata[47:32];
                got.eot      = m_tuser[0];
                got.status   = m_tuser[2:1];
                got.last     = m_tlast;
                if (expected_prds.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected: addr %h bytes_m1 %h eot %b st %0d last %b",
                                 got.addr, got.bytes_m1, got.eot, got.status, got.last);
                    end
                end else begin
                    want = expected_prds.pop_front();
                    if (got.addr !== want.addr || got.bytes_m1 !== want.bytes_m1 ||
                        got.eot !== want.eot || got.status !== want.status ||
                        got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("expected: addr %h bytes_m1 %h eot %b st %0d last %b",
                                     want.addr, want.bytes_m1, want.eot, want.status,
                                     want.last);
                            $display("actual:   addr %h bytes_m1 %h eot %b st %0d last %b",
                                     got.addr, got.bytes_m1, got.eot, got.status,
                                     got.last);
                        end
                    end
                end
            end
        end
    end

    // Offers one request word, idling first at random, and returns at the
    // edge where it is taken. tvalid is left high; the next call decides.
    task automatic send_request(input logic [31:0] addr, input logic [15:0] count);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {count, addr};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic test_count_limits();
        send_request(32'h0010_0000, 16'd0);
        send_request(32'h0010_0000, 16'd1);
        send_request(32'h0010_0000, 16'(prd_pkg::SECS_PER_ENTRY));
        send_request(32'h0010_0000, 16'(prd_pkg::SECS_PER_ENTRY + 1));
        send_request(32'h0020_0000, 16'(prd_pkg::MAX_COUNT));
        send_request(32'h0020_0000, 16'(prd_pkg::MAX_COUNT + 1));
        send_request(32'h0000_0000, 16'hFFFF);
        send_request(32'hFFFF_FFFF, 16'h8000);
    endtask

    task automatic test_boundaries();
        // Less than one sector left before the wrap to zero.
        send_request(32'hFFFF_FFFF, 16'd1);
        // Table that runs across the wrap to zero.
        send_request(32'hFFFF_0000, 16'd200);
        // One whole sector before the boundary, then onwards.
        send_request(32'h0000_FE00, 16'd3);
        // Half a sector before the boundary: rejected with no entries.
        send_request(32'h0000_FF00, 16'd3);
        // Misaligned start that hits the boundary after some entries.
        send_request(32'h0000_0100, 16'd200);
        // Full-length entry ending exactly on the boundary.
        send_request(32'h0000_8200, 16'd63);
        send_request(32'h0000_8201, 16'd63);
        send_request(32'h0000_0000, 16'd1);
    endtask

    task automatic test_table_full();
        // The boundaries keep cutting entries short, so the table runs out
        // before the sectors do.
        send_request(32'h0000_8000, 16'(prd_pkg::MAX_COUNT));
        send_request(32'h0000_FE00, 16'd2000);
    endtask

    task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                       input int unsigned n_items);
        logic [31:0] addr;
        logic [15:0] count;
        int unsigned pick;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                // Noise: mostly counts that cannot fit, now and then zero.
                count = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom());
            end else if (pick < 20) begin
                count = 16'($urandom_range(prd_pkg::MAX_COUNT + 3,
                                           prd_pkg::MAX_COUNT - 3));
            end else if (pick < 60) begin
                count = 16'($urandom_range(200, 1));
            end else begin
                count = 16'($urandom_range(prd_pkg::MAX_COUNT, 1));
            end
            pick = $urandom_range(3);
            addr = $urandom();
            if (pick < 2) begin
                addr[8:0] = '0;
            end else if (pick == 2) begin
                addr[15:0] = 16'(17'h10000 - $urandom_range(16'h2000, 1));
            end
            send_request(addr, count);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        stall_pct = 25;
        test_count_limits();
        test_boundaries();
        test_table_full();
        test_random_traffic(0, 0, 66);
        test_random_traffic(75, 0, 66);
        test_random_traffic(0, 75, 66);
        test_random_traffic(13, 13, 66);
        s_tvalid <= 1'b0;
        while (expected_prds.size() != 0) @(posedge aclk);
        // Let any stray word come out before the verdict.
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && expected_prds.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/prd_pkg.sv
rtl/prd_dp.sv
rtl/prd_ctrl.sv
rtl/ata_prd_table_builder.sv
verif/testbench.sv
